@@ hdl/lsh_pkg.sv @@
// ----------------------------------------------------------------------------
// lsh_pkg
// Shared constants and types of the 3x3 Laplacian sharpen block: frame
// limits, register indexes, pixel and position records.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsh_pkg;

   // frame limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   // column and row counters, and the 11-bit dimension registers
   localparam int COL_W = 10;
   localparam int ROW_W = 10;
   localparam int DIM_W = 11;

   // configuration register indexes
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   // register reset values
   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

   // one RGB pixel, red in the low byte
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pix_type;

   // line store entry: pixel two rows up and one row up at this column
   typedef struct packed {
      pix_type upper;
      pix_type middle;
   } line_pair_type;

   // position of the incoming pixel and what it causes
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             emit;
      logic             last;
   } pos_type;

endpackage

@@ hdl/lsh_position.sv @@
// ----------------------------------------------------------------------------
// lsh_position
// Column and row tracking of the incoming pixel stream: frame start, wrap
// at the clamped width and height, interior and last-pixel flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsh_position
   import lsh_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             frame_start,
   input  logic [DIM_W-1:0] image_width,
   input  logic [DIM_W-1:0] image_height,
   output pos_type          pos
);

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic [DIM_W-1:0] w_eff, h_eff;
   logic [DIM_W-1:0] c0, r0, c1, r1, r2, cn, rn;

   // clamp a dimension register to 3..limit
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] lim);
      logic [DIM_W-1:0] res;
      if (v < DIM_W'(3)) res = DIM_W'(3);
      else if (v > lim)  res = lim;
      else               res = v;
      return res;
   endfunction

   assign w_eff = clamp_dim(image_width,  DIM_W'(MAX_WIDTH));
   assign h_eff = clamp_dim(image_height, DIM_W'(MAX_HEIGHT));

   // position of the current pixel
   always_comb begin
      c0 = frame_start ? '0 : DIM_W'(col_ff);
      r0 = frame_start ? '0 : DIM_W'(row_ff);
      if (c0 >= w_eff) begin
         c1 = '0;
         r1 = r0 + DIM_W'(1);
      end else begin
         c1 = c0;
         r1 = r0;
      end
      r2 = (r1 >= h_eff) ? '0 : r1;
   end

   // position of the next pixel
   always_comb begin
      cn = c1 + DIM_W'(1);
      rn = r2;
      if (cn >= w_eff) begin
         cn = '0;
         rn = r2 + DIM_W'(1);
         if (rn >= h_eff) rn = '0;
      end
      col_in = cn[COL_W-1:0];
      row_in = rn[ROW_W-1:0];
   end

   always_comb begin
      pos.col  = c1[COL_W-1:0];
      pos.row  = r2[ROW_W-1:0];
      pos.emit = (c1 >= DIM_W'(2)) && (r2 >= DIM_W'(2));
      pos.last = (c1 == w_eff - DIM_W'(1)) && (r2 == h_eff - DIM_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (advance) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

@@ hdl/lsh_line_mem.sv @@
// ----------------------------------------------------------------------------
// lsh_line_mem
// Two line stores in one memory, one write and one registered read port.
// A read at the address written on the same edge returns the new data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsh_line_mem
   import lsh_pkg::*;
(
   input  logic             clock,
   input  logic             rd_en,
   input  logic [COL_W-1:0] rd_addr,
   output line_pair_type    rd_data,
   input  logic             wr_en,
   input  logic [COL_W-1:0] wr_addr,
   input  line_pair_type    wr_data
);

   line_pair_type mem [MAX_WIDTH];
   line_pair_type rd_ff;
   line_pair_type byp_data_ff;
   logic          byp_ff;

   // storage: read returns old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   // write-to-read bypass
   always_ff @(posedge clock) begin
      if (rd_en) begin
         byp_ff      <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= wr_data;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_ff;

endmodule

@@ hdl/lsh_kernel.sv @@
// ----------------------------------------------------------------------------
// lsh_kernel
// 3x3 Laplacian sharpen of one RGB window: per channel nine times the
// centre minus the eight neighbours, clamped to 0..255.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsh_kernel
   import lsh_pkg::*;
(
   input  pix_type [8:0] nb,
   output pix_type       result
);

   localparam int CENTER = 4;

   logic [10:0] sum_r, sum_g, sum_b;

   function automatic logic [7:0] sharpen_chan(input logic [7:0]  ctr,
                                               input logic [10:0] nsum);
      logic signed [12:0] s;
      s = $signed({2'b00, ctr, 3'b000}) + $signed({5'b00000, ctr})
          - $signed({2'b00, nsum});
      if (s < 13'sd0)        return 8'd0;
      else if (s > 13'sd255) return 8'd255;
      else                   return s[7:0];
   endfunction

   // neighbour sums
   always_comb begin
      sum_r = '0;
      sum_g = '0;
      sum_b = '0;
      for (int k = 0; k < 9; k++) begin
         if (k != CENTER) begin
            sum_r = sum_r + 11'(nb[k].red);
            sum_g = sum_g + 11'(nb[k].green);
            sum_b = sum_b + 11'(nb[k].blue);
         end
      end
   end

   assign result.red   = sharpen_chan(nb[CENTER].red,   sum_r);
   assign result.green = sharpen_chan(nb[CENTER].green, sum_g);
   assign result.blue  = sharpen_chan(nb[CENTER].blue,  sum_b);

endmodule

@@ hdl/rgb_laplacian_sharpen_3x3.sv @@
// ----------------------------------------------------------------------------
// rgb_laplacian_sharpen_3x3
// Pipeline: input register with the line memory read, then the result register.
// Throughput: one pixel per cycle while the output is not stalled, set by the
//   single line memory port pair.
// Reset: synchronous, clears counters, valids and registers to 640 x 480;
//   line stores and window hold no reset value and no clearing pass is run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_laplacian_sharpen_3x3
   import lsh_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // pixel input
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [23:0]      req_tdata,   // red_in, green_in, blue_in
   input  logic             req_tuser,   // frame_start
   // sharpened output
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [47:0]      rsp_tdata,   // red, green, blue, pixel_column, pixel_row, pad
   output logic             rsp_tlast,   // frame_last
   // configuration
   input  logic             csr_we,
   input  logic             csr_addr,
   input  logic [DIM_W-1:0] csr_wdata
);

   logic [DIM_W-1:0] width_ff, height_ff;

   logic          req_acc;
   logic          s1_adv;
   logic          s1_valid_ff, s1_valid_in;
   pix_type       s1_px_ff;
   pos_type       s1_pos_ff;
   pos_type       pos;

   line_pair_type lines;
   line_pair_type wr_pair;

   pix_type [1:0] win_top_ff, win_mid_ff, win_bot_ff;
   pix_type [8:0] nb;
   pix_type       sharp;

   logic             rsp_valid_ff, rsp_valid_in;
   pix_type          rsp_px_ff;
   logic [COL_W-1:0] rsp_col_ff;
   logic [ROW_W-1:0] rsp_row_ff;
   logic             rsp_last_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            REG_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            REG_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_acc    = req_tvalid && req_tready;

   lsh_position u_position (
      .clock        (clock),
      .reset        (reset),
      .advance      (req_acc),
      .frame_start  (req_tuser),
      .image_width  (width_ff),
      .image_height (height_ff),
      .pos          (pos)
   );

   // input stage
   assign s1_valid_in = req_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= s1_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_px_ff  <= pix_type'(req_tdata);
         s1_pos_ff <= pos;
      end
   end

   // line stores: upper takes the middle row, middle takes the new pixel
   assign wr_pair.upper  = lines.middle;
   assign wr_pair.middle = s1_px_ff;

   lsh_line_mem u_line_mem (
      .clock   (clock),
      .rd_en   (req_acc),
      .rd_addr (pos.col),
      .rd_data (lines),
      .wr_en   (s1_adv),
      .wr_addr (s1_pos_ff.col),
      .wr_data (wr_pair)
   );

   // window shift on each pixel leaving the input stage
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         win_top_ff <= {lines.upper,  win_top_ff[1]};
         win_mid_ff <= {lines.middle, win_mid_ff[1]};
         win_bot_ff <= {s1_px_ff,     win_bot_ff[1]};
      end
   end

   assign nb = {s1_px_ff,     win_bot_ff[1], win_bot_ff[0],
                lines.middle, win_mid_ff[1], win_mid_ff[0],
                lines.upper,  win_top_ff[1], win_top_ff[0]};

   lsh_kernel u_kernel (
      .nb     (nb),
      .result (sharp)
   );

   // result register
   always_comb begin
      if (s1_adv)                        rsp_valid_in = s1_pos_ff.emit;
      else if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      else                               rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_pos_ff.emit) begin
         rsp_px_ff   <= sharp;
         rsp_col_ff  <= s1_pos_ff.col - COL_W'(1);
         rsp_row_ff  <= s1_pos_ff.row - ROW_W'(1);
         rsp_last_ff <= s1_pos_ff.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_row_ff, rsp_col_ff, rsp_px_ff};
   assign rsp_tlast  = rsp_last_ff;

   // checks
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> s1_valid_ff)
      else $error("accepted pixel missing from input stage");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_pos_ff.emit |=> rsp_tvalid && rsp_col_ff == $past(s1_pos_ff.col) - COL_W'(1))
      else $error("interior pixel result lost");

   a_skip_border: assert property (@(posedge clock) disable iff (reset)
      s1_adv && !s1_pos_ff.emit |=> !rsp_tvalid)
      else $error("border pixel produced a result");

   a_interior_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_col_ff != '0 && rsp_row_ff != '0)
      else $error("result centred on a border pixel");

endmodule

@@ verif/tb_rgb_laplacian_sharpen_3x3.sv @@
// ----------------------------------------------------------------------------
// tb_rgb_laplacian_sharpen_3x3
// Self-checking bench for the 3x3 Laplacian sharpen stage. A queue-fed driver
// streams RGB pixels in bursts, a receiver stalls on its own pattern, and a
// monitor predicts every interior pixel from its own line stores and window,
// then compares each result transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rgb_laplacian_sharpen_3x3;
   import lsh_pkg::*;

   localparam int RANDOM_PIXELS = 790;
   localparam int SETTLE_CYCLES = 8;
   localparam int IDLE_LIMIT    = 4000;
   localparam int LONG_HOLD     = 400;

   // pixel waiting to be driven
   typedef struct packed {
      logic    sof;
      pix_type pix;
   } feed_item_type;

   // one expected sharpened pixel
   typedef struct packed {
      logic             frame_end;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      pix_type          pix;
   } sharp_result_type;

   // receiver stall patterns
   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_MOSTLY
   } ready_mode_type;

   // DUT ports
   logic             clock;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [23:0]      req_tdata  = '0;   // red_in, green_in, blue_in
   logic             req_tuser  = 1'b0; // frame_start
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [47:0]      rsp_tdata;         // red, green, blue, pixel_column, pixel_row, pad
   logic             rsp_tlast;         // frame_last
   logic             csr_we     = 1'b0;
   logic             csr_addr   = REG_IMAGE_WIDTH;
   logic [DIM_W-1:0] csr_wdata  = '0;

   // stimulus and scoreboard
   feed_item_type    pixel_feed [$];
   sharp_result_type expected_pixels [$];
   int unsigned      items_queued   = 0;
   int unsigned      items_taken    = 0;
   int unsigned      mismatch_count = 0;
   logic             req_taken      = 1'b0;

   // predictor state
   logic [DIM_W-1:0] width_reg;
   logic [DIM_W-1:0] height_reg;
   pix_type          upper_line  [MAX_WIDTH];
   pix_type          middle_line [MAX_WIDTH];
   byte unsigned     write_hits  [MAX_WIDTH];
   pix_type          win [6];
   int unsigned      col_pos;
   int unsigned      row_pos;

   // driver and receiver state
   feed_item_type  next_feed;
   int unsigned    burst_left     = 0;
   int unsigned    gap_left       = 0;
   int unsigned    hold_left      = 0;
   bit             long_hold_done = 1'b0;
   ready_mode_type ready_mode     = READY_ALWAYS;
   int unsigned    mode_left      = 0;
   int unsigned    idle_cycles    = 0;

   // result transaction checking
   sharp_result_type want;
   sharp_result_type got;

   rgb_laplacian_sharpen_3x3 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // predictor helpers
   // ------------------------------------------------------------------
   function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned maxv);
      if (v < 3) return 3;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic logic [7:0] clamp_chan(input int s);
      if (s > 255) return 8'd255;
      if (s < 0) return 8'd0;
      return s[7:0];
   endfunction

   // true when every store entry below w has seen two rows
   function automatic bit stores_ready(input int unsigned w);
      for (int c = 0; c < w; c++)
         if (write_hits[c] < 2) return 1'b0;
      return 1'b1;
   endfunction

   // advance the position counters and line stores by one pixel, queuing the expected result of an interior pixel
   task automatic sharpen_predict(input pix_type px, input logic sof);
      int unsigned      w, h, c, r;
      pix_type          top, mid;
      pix_type          nb [9];
      int               sr, sg, sb;
      sharp_result_type res;
      w = eff_dim(width_reg, MAX_WIDTH);
      h = eff_dim(height_reg, MAX_HEIGHT);
      if (sof) begin
         col_pos = 0;
         row_pos = 0;
      end
      // counters left past a shrunk frame
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      c = col_pos;
      r = row_pos;
      top = upper_line[c];
      mid = middle_line[c];

      if (c >= 2 && r >= 2) begin
         nb[0] = win[0]; nb[1] = win[1]; nb[2] = top;
         nb[3] = win[2]; nb[4] = win[3]; nb[5] = mid;
         nb[6] = win[4]; nb[7] = win[5]; nb[8] = px;
         sr = 9 * int'(nb[4].red);
         sg = 9 * int'(nb[4].green);
         sb = 9 * int'(nb[4].blue);
         for (int k = 0; k < 9; k++) begin
            if (k != 4) begin
               sr -= int'(nb[k].red);
               sg -= int'(nb[k].green);
               sb -= int'(nb[k].blue);
            end
         end
         res.pix.red   = clamp_chan(sr);
         res.pix.green = clamp_chan(sg);
         res.pix.blue  = clamp_chan(sb);
         res.col       = COL_W'(c - 1);
         res.row       = ROW_W'(r - 1);
         res.frame_end = (c == w - 1) && (r == h - 1);
         expected_pixels.push_back(res);
      end

      // window shift and line store update
      win[0] = win[1]; win[1] = top;
      win[2] = win[3]; win[3] = mid;
      win[4] = win[5]; win[5] = px;
      upper_line[c]  = mid;
      middle_line[c] = px;
      if (write_hits[c] < 2) write_hits[c]++;

      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   task automatic flag_mismatch(input string what, input int got_val, input int want_val);
      mismatch_count++;
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got_val, want_val);
   endtask

   // ------------------------------------------------------------------
   // monitor: predictor on input transactions, checker on results
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         col_pos    = 0;
         row_pos    = 0;
         for (int c = 0; c < MAX_WIDTH; c++) write_hits[c] = 0;
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (csr_we) begin
            if (csr_addr == REG_IMAGE_WIDTH) width_reg = csr_wdata;
            else height_reg = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            sharpen_predict(pix_type'(req_tdata), req_tuser);
            items_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.pix       = rsp_tdata[23:0];
            got.col       = rsp_tdata[33:24];
            got.row       = rsp_tdata[43:34];
            got.frame_end = rsp_tlast;
            if (expected_pixels.size() == 0) begin
               flag_mismatch("result with nothing expected", 1, 0);
            end else begin
               want = expected_pixels.pop_front();
               if (got.pix.red != want.pix.red)
                  flag_mismatch("red_out", got.pix.red, want.pix.red);
               if (got.pix.green != want.pix.green)
                  flag_mismatch("green_out", got.pix.green, want.pix.green);
               if (got.pix.blue != want.pix.blue)
                  flag_mismatch("blue_out", got.pix.blue, want.pix.blue);
               if (got.col != want.col)
                  flag_mismatch("pixel_column", got.col, want.col);
               if (got.row != want.row)
                  flag_mismatch("pixel_row", got.row, want.row);
               if (got.frame_end != want.frame_end)
                  flag_mismatch("frame_last", got.frame_end, want.frame_end);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // driver: bursts of pixels with random gaps
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            req_tvalid <= 1'b0;
            gap_left   <= gap_left - 1;
         end else if (pixel_feed.size() != 0) begin
            next_feed = pixel_feed.pop_front();
            req_tdata  <= next_feed.pix;
            req_tuser  <= next_feed.sof;
            req_tvalid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // receiver: changing stall pattern plus one long hold-off
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (!long_hold_done && pixel_feed.size() > 200) begin
         // back up the pipe while the driver keeps offering
         long_hold_done <= 1'b1;
         hold_left      <= LONG_HOLD;
         rsp_tready     <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode <= ready_mode_type'($urandom_range(0, 3));
            mode_left  <= $urandom_range(16, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (ready_mode)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_COIN:   rsp_tready <= $urandom_range(0, 1);
            READY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:      rsp_tready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // ------------------------------------------------------------------
   // watchdog: cycles without any transaction
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] no transaction for %0d cycles", $realtime, IDLE_LIMIT);
            $display("** rgb_laplacian_sharpen_3x3: FAILED **");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   function automatic logic [7:0] rand_chan();
      case ($urandom_range(0, 3))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic sof);
      feed_item_type item;
      item.pix.red   = r;
      item.pix.green = g;
      item.pix.blue  = b;
      item.sof       = sof;
      pixel_feed.push_back(item);
      items_queued++;
   endtask

   // all pixels taken, all results seen, pipeline flushed
   task automatic wait_drained();
      while (items_taken != items_queued || expected_pixels.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [DIM_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // reconfigure, then stream n_px random pixels; an open start keeps the
   // counters running across the register change when the stores allow it
   task automatic stream_frames(input logic [DIM_W-1:0] w_val, input logic [DIM_W-1:0] h_val,
                                input int unsigned n_px, input bit open_start,
                                input bit with_noise);
      int unsigned w, h;
      bit          first_sof;
      bit          sof;
      wait_drained();
      csr_write(REG_IMAGE_WIDTH, w_val);
      csr_write(REG_IMAGE_HEIGHT, h_val);
      w = eff_dim(w_val, MAX_WIDTH);
      h = eff_dim(h_val, MAX_HEIGHT);
      first_sof = !(open_start && stores_ready(w));
      for (int i = 0; i < n_px; i++) begin
         sof = (i == 0) && first_sof;
         if (with_noise) begin
            // stray frame starts, and frame starts sometimes dropped
            if ($urandom_range(0, 63) == 0) sof = 1'b1;
            if (i != 0 && i % (w * h) == 0 && $urandom_range(0, 1) == 1) sof = 1'b1;
         end
         queue_pixel(rand_chan(), rand_chan(), rand_chan(), sof);
      end
   endtask

   initial begin
      int unsigned      random_px;
      int unsigned      n_px;
      logic [DIM_W-1:0] w_val;
      logic [DIM_W-1:0] h_val;

      random_px = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: 4 x 3 frame, height below the legal minimum
      wait_drained();
      csr_write(REG_IMAGE_WIDTH, 11'd4);
      csr_write(REG_IMAGE_HEIGHT, 11'd0);
      queue_pixel(8'h00, 8'h00, 8'h00, 1'b1);
      queue_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      queue_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      queue_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      queue_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
      queue_pixel(8'hFF, 8'h00, 8'h40, 1'b0);   // saturates high, low, mid
      queue_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      queue_pixel(8'h00, 8'hFF, 8'hFF, 1'b0);
      queue_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      queue_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      queue_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      queue_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      // no frame start: counters wrap into a new frame
      queue_pixel(8'h80, 8'h7F, 8'h01, 1'b0);
      queue_pixel(8'hFE, 8'h10, 8'hFF, 1'b0);
      queue_pixel(8'h55, 8'hAA, 8'h00, 1'b0);
      // width cut mid-row below the column counter, width below minimum
      wait_drained();
      csr_write(REG_IMAGE_WIDTH, 11'd1);
      queue_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
      queue_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
      queue_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
      queue_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
      queue_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
      queue_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);

      // random frames, mostly small
      while (random_px < RANDOM_PIXELS) begin
         case ($urandom_range(0, 9))
            0:       w_val = DIM_W'($urandom_range(0, 2));
            1, 2:    w_val = DIM_W'($urandom_range(13, 40));
            default: w_val = DIM_W'($urandom_range(3, 12));
         endcase
         case ($urandom_range(0, 9))
            0:       h_val = DIM_W'($urandom_range(0, 2));
            default: h_val = DIM_W'($urandom_range(3, 8));
         endcase
         n_px = eff_dim(w_val, MAX_WIDTH) * eff_dim(h_val, MAX_HEIGHT) * $urandom_range(1, 3)
                + $urandom_range(0, 2 * eff_dim(w_val, MAX_WIDTH));
         if (n_px > RANDOM_PIXELS - random_px) n_px = RANDOM_PIXELS - random_px;
         stream_frames(w_val, h_val, n_px, $urandom_range(0, 3) == 0, 1'b1);
         random_px += n_px;
      end

      // tall narrow frame, height register above the legal maximum
      stream_frames(11'd3, 11'h7FF, 240, 1'b0, 1'b0);

      wait_drained();
      if (expected_pixels.size() != 0)
         flag_mismatch("results never produced", expected_pixels.size(), 0);
      if (mismatch_count == 0) begin
         $display("** rgb_laplacian_sharpen_3x3: PASSED **");
      end else begin
         $display("** rgb_laplacian_sharpen_3x3: FAILED **");
      end
      $finish;
   end

endmodule
